@@ hw/rtl/lbs_pkg.sv @@
// Shared types, constants and arithmetic helpers for the skinning engine.
package lbs_pkg;

  localparam int unsigned VecW  = 32;
  localparam int unsigned QuatW = 16;
  localparam int unsigned AccW  = 48;
  localparam int unsigned PosW  = 32;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpWeight = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StRot,
    StNorm,
    StAcc,
    StOut
  } state_e;

  typedef struct packed {
    logic signed [QuatW-1:0] x;
    logic signed [QuatW-1:0] y;
    logic signed [QuatW-1:0] z;
    logic signed [QuatW-1:0] w;
  } quat_t;

  // Round half up, then arithmetic shift right by k.
  function automatic logic signed [63:0] round_shr(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] t;
    t = x + (64'sd1 <<< (k - 1));
    return t >>> k;
  endfunction

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] x);
    logic signed [AccW:0] mx;
    logic signed [AccW:0] mn;
    mx = {2'b00, {(AccW-1){1'b1}}};
    mn = {2'b11, {(AccW-1){1'b0}}};
    if (x > mx) return mx[AccW-1:0];
    if (x < mn) return mn[AccW-1:0];
    return x[AccW-1:0];
  endfunction

  function automatic logic signed [PosW-1:0] sat_out(input logic signed [AccW-1:0] x);
    if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return x[PosW-1:0];
  endfunction

endpackage

@@ hw/rtl/lbs_rotate.sv @@
// Quaternion vector rotation in three registered steps.
module lbs_rotate (
  input  logic                      clk_i,
  input  logic [1:0]                step_i,
  input  lbs_pkg::quat_t            q_i,
  input  logic signed [47:0]        v_i [3],
  output logic signed [47:0]        r_o [3]
);
  logic signed [47:0] uv_q [3];
  logic signed [63:0] uuv_q [3];
  logic signed [63:0] qx, qy, qz, qw;

  assign qx = 64'(q_i.x);
  assign qy = 64'(q_i.y);
  assign qz = 64'(q_i.z);
  assign qw = 64'(q_i.w);

  // Step 1 forms uv, step 2 forms uuv, step 3 the result.
  always_ff @(posedge clk_i) begin
    if (step_i == 2'd1) begin
      uv_q[0] <= 48'(lbs_pkg::round_shr(qy * 64'(v_i[2]) - qz * 64'(v_i[1]), 14));
      uv_q[1] <= 48'(lbs_pkg::round_shr(qz * 64'(v_i[0]) - qx * 64'(v_i[2]), 14));
      uv_q[2] <= 48'(lbs_pkg::round_shr(qx * 64'(v_i[1]) - qy * 64'(v_i[0]), 14));
    end
    if (step_i == 2'd2) begin
      uuv_q[0] <= qy * 64'(uv_q[2]) - qz * 64'(uv_q[1]);
      uuv_q[1] <= qz * 64'(uv_q[0]) - qx * 64'(uv_q[2]);
      uuv_q[2] <= qx * 64'(uv_q[1]) - qy * 64'(uv_q[0]);
    end
    if (step_i == 2'd3) begin
      for (int i = 0; i < 3; i++) begin
        r_o[i] <= v_i[i] + 48'(lbs_pkg::round_shr(64'(uv_q[i]) * qw + uuv_q[i], 13));
      end
    end
  end
endmodule

@@ hw/rtl/linear_blend_skinning_top.sv @@
// Top level of the quaternion linear blend skinning engine.
// Usage:
//   One input channel (in_valid_i/in_ready_o) carries load and weight beats.
//   A load beat (op 0) writes one joint pose into the joint memory.
//   A weight beat (op 1) reads the joint, rotates offset and normal, scales
//   them by the bias and adds them to saturating 48-bit accumulators.
//   A weight beat with last set produces one output beat (out_valid_o /
//   out_ready_i) with the saturated position and normal, then clears sums.
// Sequencing: a load is taken in idle and leaves the input open; a weight goes
//   through idle to take the beat, StRead to read the joint memory, three
//   rotation steps for the offset, four for the normal (three steps and one
//   spare), and one to accumulate. A last weight then passes StOut, which
//   fills the output register and raises out_valid_o.
// The output register holds its beat while the receiver stalls; the next
//   item is still taken, and a new result waits only if the register is full.
// Reset clears accumulators and control; the joint memory is undefined
//   until written and takes no clearing pass.
module linear_blend_skinning_top #(
  parameter int unsigned MAX_JOINTS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [6:0]         joint_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic [15:0]        bias_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o
);
  localparam int unsigned IdxW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  lbs_pkg::state_e state_q, state_d;
  logic [1:0] sub_q, sub_d;

  logic [95:0]        pos_mem [MAX_JOINTS];
  lbs_pkg::quat_t     rot_mem [MAX_JOINTS];
  logic [95:0]        pos_rd_q;
  lbs_pkg::quat_t     rot_rd_q;

  logic signed [47:0] v_q [3];
  logic signed [47:0] n_q [3];
  logic [15:0]        bias_q;
  logic               last_q;
  logic               hit_q;
  logic signed [47:0] rp_q [3];
  logic signed [47:0] acc_p_q [3];
  logic signed [47:0] acc_n_q [3];
  logic               out_valid_q;
  logic signed [31:0] out_q [6];

  logic               in_hs, in_table;
  logic [IdxW-1:0]    idx;
  lbs_pkg::quat_t     q_use;
  logic signed [47:0] rot_v [3];
  logic signed [47:0] rot_r [3];
  logic [1:0]         rot_step;

  assign in_hs    = in_valid_i && in_ready_o;
  assign in_table = 32'(joint_i) < MAX_JOINTS;
  assign idx      = IdxW'(joint_i);

  // Joint memory: a write on each accepted in-table load beat and a read on every
  // accepted beat, registered read data that stays put until the next beat.
  always_ff @(posedge clk_i) begin
    if (in_hs && op_i == lbs_pkg::OpLoad && in_table) begin
      pos_mem[idx] <= {vec_z_i, vec_y_i, vec_x_i};
      rot_mem[idx] <= '{x: quat_x_i, y: quat_y_i, z: quat_z_i, w: quat_w_i};
    end
    if (in_hs) begin
      pos_rd_q <= pos_mem[idx];
      rot_rd_q <= rot_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      v_q[0] <= 48'(vec_x_i);
      v_q[1] <= 48'(vec_y_i);
      v_q[2] <= 48'(vec_z_i);
      n_q[0] <= 48'(quat_x_i) <<< 2;
      n_q[1] <= 48'(quat_y_i) <<< 2;
      n_q[2] <= 48'(quat_z_i) <<< 2;
      bias_q <= bias_i;
      last_q <= last_i;
      hit_q  <= in_table;
    end
    if (state_q == lbs_pkg::StNorm && sub_q == 2'd0) begin
      rp_q <= rot_r;
    end
  end

  // Out-of-table joints use a zero quaternion and zero position.
  assign q_use = hit_q ? rot_rd_q : '0;
  assign rot_v = (state_q == lbs_pkg::StNorm) ? n_q : v_q;
  assign rot_step = (state_q == lbs_pkg::StRot || state_q == lbs_pkg::StNorm) ?
                    sub_q + 2'd1 : 2'd0;

  lbs_rotate u_rot (
    .clk_i  (clk_i),
    .step_i (rot_step),
    .q_i    (q_use),
    .v_i    (rot_v),
    .r_o    (rot_r)
  );

  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    case (state_q)
      lbs_pkg::StIdle: if (in_hs && op_i == lbs_pkg::OpWeight) state_d = lbs_pkg::StRead;
      lbs_pkg::StRead: begin
        state_d = lbs_pkg::StRot;
        sub_d   = 2'd0;
      end
      lbs_pkg::StRot: begin
        if (sub_q == 2'd2) begin
          state_d = lbs_pkg::StNorm;
          sub_d   = 2'd0;
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      lbs_pkg::StNorm: begin
        if (sub_q == 2'd3) begin
          state_d = lbs_pkg::StAcc;
          sub_d   = 2'd0;
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      lbs_pkg::StAcc: state_d = last_q ? lbs_pkg::StOut : lbs_pkg::StIdle;
      lbs_pkg::StOut: if (!out_valid_q || out_ready_i) state_d = lbs_pkg::StIdle;
      default: state_d = lbs_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == lbs_pkg::StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbs_pkg::StIdle;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_p_q[i] <= '0;
        acc_n_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      if (state_q == lbs_pkg::StOut && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == lbs_pkg::StAcc) begin
        for (int i = 0; i < 3; i++) begin
          acc_p_q[i] <= lbs_pkg::sat_acc(49'(acc_p_q[i]) + 49'(lbs_pkg::round_shr(
              (64'((hit_q ? 48'($signed(pos_rd_q[32*i +: 32])) : 48'sd0) + rp_q[i]))
              * $signed({48'd0, bias_q}), 15)));
          acc_n_q[i] <= lbs_pkg::sat_acc(49'(acc_n_q[i]) + 49'(lbs_pkg::round_shr(
              64'(rot_r[i]) * $signed({48'd0, bias_q}), 15)));
        end
      end
      if (state_q == lbs_pkg::StOut && (!out_valid_q || out_ready_i)) begin
        for (int i = 0; i < 3; i++) begin
          acc_p_q[i] <= '0;
          acc_n_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lbs_pkg::StOut && (!out_valid_q || out_ready_i)) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i]     <= lbs_pkg::sat_out(acc_p_q[i]);
        out_q[3 + i] <= lbs_pkg::sat_out(acc_n_q[i]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_q[0];
  assign pos_y_o     = out_q[1];
  assign pos_z_o     = out_q[2];
  assign normal_x_o  = out_q[3];
  assign normal_y_o  = out_q[4];
  assign normal_z_o  = out_q[5];
endmodule

@@ hw/rtl/lbs_checker.sv @@
// Port-level assertions for the skinning engine, bound to the top level.
module lbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        op_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pos_x_o
);
  // A result beat never appears right after a load beat alone.
  a_no_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == 1'b0 && !out_valid_o |=> !$rose(out_valid_o))
    else $error("result after load");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o))
    else $error("output beat dropped");

  // A weight beat keeps the input closed in the next cycle.
  a_weight_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == 1'b1 |=> !in_ready_o)
    else $error("weight not serialized");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid out of reset");
endmodule

bind linear_blend_skinning_top lbs_checker u_lbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the quaternion linear blend skinning engine.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic signed [31:0] px, py, pz, nx, ny, nz;
  } vertex_t;

  typedef struct {
    logic               op;
    logic [6:0]         joint;
    logic signed [31:0] vx, vy, vz;
    logic signed [15:0] qx, qy, qz, qw;
    logic [15:0]        bias;
    logic               last;
  } beat_t;

  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam longint OutMax = 64'sh7FFF_FFFF;
  localparam longint OutMin = -OutMax - 1;
  localparam longint LimitCycles = 400000;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  class skin_scoreboard;
    longint pose_pos[128][3];
    longint pose_rot[128][4];
    longint pos_sum[3];
    longint nrm_sum[3];
    vertex_t pending[$];

    function longint rnd_shr(longint x, int k);
      return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function void spin(longint q[4], longint v[3], output longint r[3]);
      longint uv[3], uuv[3];
      uv[0] = rnd_shr(q[1] * v[2] - q[2] * v[1], 14);
      uv[1] = rnd_shr(q[2] * v[0] - q[0] * v[2], 14);
      uv[2] = rnd_shr(q[0] * v[1] - q[1] * v[0], 14);
      uuv[0] = q[1] * uv[2] - q[2] * uv[1];
      uuv[1] = q[2] * uv[0] - q[0] * uv[2];
      uuv[2] = q[0] * uv[1] - q[1] * uv[0];
      for (int i = 0; i < 3; i++) r[i] = v[i] + rnd_shr(uv[i] * q[3] + uuv[i], 13);
    endfunction

    function void note_beat(beat_t b);
      longint v[3], n[3], q[4], rp[3], rn[3];
      vertex_t e;
      if (b.op == lbs_pkg::OpLoad) begin
        pose_pos[b.joint] = '{b.vx, b.vy, b.vz};
        pose_rot[b.joint] = '{b.qx, b.qy, b.qz, b.qw};
        return;
      end
      v = '{b.vx, b.vy, b.vz};
      n = '{longint'(b.qx) * 4, longint'(b.qy) * 4, longint'(b.qz) * 4};
      q = pose_rot[b.joint];
      spin(q, v, rp);
      spin(q, n, rn);
      for (int i = 0; i < 3; i++) begin
        pos_sum[i] = clip(pos_sum[i] +
          rnd_shr((pose_pos[b.joint][i] + rp[i]) * longint'(b.bias), 15), AccMin, AccMax);
        nrm_sum[i] = clip(nrm_sum[i] + rnd_shr(rn[i] * longint'(b.bias), 15), AccMin, AccMax);
      end
      if (!b.last) return;
      e.px = 32'(clip(pos_sum[0], OutMin, OutMax));
      e.py = 32'(clip(pos_sum[1], OutMin, OutMax));
      e.pz = 32'(clip(pos_sum[2], OutMin, OutMax));
      e.nx = 32'(clip(nrm_sum[0], OutMin, OutMax));
      e.ny = 32'(clip(nrm_sum[1], OutMin, OutMax));
      e.nz = 32'(clip(nrm_sum[2], OutMin, OutMax));
      pending.insert(pending.size(), e);
      pos_sum = '{0, 0, 0};
      nrm_sum = '{0, 0, 0};
    endfunction

    task check_vertex(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        report("output beat with no vertex expected");
        return;
      end
      e = pending.pop_front();
      if (got.px !== e.px) report($sformatf("pos_x %0d exp %0d", got.px, e.px));
      if (got.py !== e.py) report($sformatf("pos_y %0d exp %0d", got.py, e.py));
      if (got.pz !== e.pz) report($sformatf("pos_z %0d exp %0d", got.pz, e.pz));
      if (got.nx !== e.nx) report($sformatf("normal_x %0d exp %0d", got.nx, e.nx));
      if (got.ny !== e.ny) report($sformatf("normal_y %0d exp %0d", got.ny, e.ny));
      if (got.nz !== e.nz) report($sformatf("normal_z %0d exp %0d", got.nz, e.nz));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic [6:0] joint_i = '0;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic [15:0] bias_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o, normal_x_o, normal_y_o, normal_z_o;

  linear_blend_skinning_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  skin_scoreboard board = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit loaded[128];
  longint cycles = 0;

  // Output side: sample at the rising edge, move ready at the falling edge.
  always @(posedge clk_i) begin
    vertex_t got;
    cycles++;
    if (cycles > LimitCycles) begin
      $display("[linear_blend_skinning_top] ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, normal_x_o, normal_y_o, normal_z_o};
      board.check_vertex(got);
    end
  end

  always @(negedge clk_i)
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall);

  // Valid drops only in idle cycles, so back-to-back beats keep it high.
  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    op_i <= b.op; joint_i <= b.joint;
    vec_x_i <= b.vx; vec_y_i <= b.vy; vec_z_i <= b.vz;
    quat_x_i <= b.qx; quat_y_i <= b.qy; quat_z_i <= b.qz; quat_w_i <= b.qw;
    bias_i <= b.bias; last_i <= b.last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_beat(b);
    if (b.op == lbs_pkg::OpLoad) loaded[b.joint] = 1'b1;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_vec();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(65536 * 200)) - 65536 * 100;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_q();
    return $urandom_range(3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic beat_t rand_load(logic [6:0] j);
    beat_t b;
    b = '{lbs_pkg::OpLoad, j, rand_vec(), rand_vec(), rand_vec(), rand_q(), rand_q(),
          rand_q(), rand_q(), 16'($urandom), 1'($urandom)};
    return b;
  endfunction

  function automatic beat_t rand_weight(logic [6:0] j, logic lst);
    beat_t b;
    b = '{lbs_pkg::OpWeight, j, rand_vec(), rand_vec(), rand_vec(), rand_q(), rand_q(),
          rand_q(), 16'($urandom),
          $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(32768)), lst};
    return b;
  endfunction

  function automatic logic [6:0] loaded_joint();
    logic [6:0] j;
    do j = $urandom; while (!loaded[j]);
    return j;
  endfunction

  initial begin
    beat_t b;
    int nw;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme joints, extreme poses, bias corners, zero rotation.
    send_beat('{lbs_pkg::OpLoad, 7'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,
                16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1});
    send_beat('{lbs_pkg::OpLoad, 7'd127, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'h0, 1'b0});
    send_beat('{lbs_pkg::OpLoad, 7'd5, 32'sd65536, -32'sd65536, 32'sd0, 0, 0, 0, 0, 0, 1'b0});
    send_beat('{lbs_pkg::OpLoad, 7'd6, 32'sd0, 32'sd0, 32'sd0, 0, 0, 0, 16'sd16384, 0, 1'b0});
    send_beat('{lbs_pkg::OpWeight, 7'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0});
    send_beat('{lbs_pkg::OpWeight, 7'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1});
    send_beat('{lbs_pkg::OpWeight, 7'd127, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                16'sh8000, 16'sh8000, 16'sh8000, 0, 16'd32768, 1'b1});
    send_beat('{lbs_pkg::OpWeight, 7'd5, 32'sd12345, -32'sd1, 32'sd3, 16'sd16384, 0, 0, 0,
                16'd32768, 1'b1});
    send_beat('{lbs_pkg::OpWeight, 7'd6, 32'sd65536, 32'sd0, -32'sd7, 0, 16'sd16384, 0, 0,
                16'd0, 1'b0});
    send_beat('{lbs_pkg::OpWeight, 7'd6, 32'sd65536, 32'sd1, -32'sd7, 0, 16'sd16384, 0, 0,
                16'd16384, 1'b1});
    // Push the sums past the 32-bit output range with many big weights.
    for (int i = 0; i < 12; i++)
      send_beat('{lbs_pkg::OpWeight, 7'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  16'sh7FFF, 16'sh7FFF, 16'sh8000, 0, 16'hFFFF, 1'(i == 11)});

    for (int phase = 0; phase < 4; phase++) begin
      send_idle  = (phase == 1) ? 50 : (phase == 3) ? 25 : 0;
      recv_stall = (phase == 2) ? 50 : (phase == 3) ? 25 : 0;
      for (int k = 0; k < 100; k += nw) begin
        if ($urandom_range(3) == 0) begin
          send_beat(rand_load(7'($urandom)));
          nw = 1;
        end else begin
          nw = $urandom_range(1, 4);
          for (int w = 0; w < nw; w++)
            send_beat(rand_weight(loaded_joint(), 1'(w == nw - 1)));
        end
      end
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("[linear_blend_skinning_top] OK");
    else
      $display("[linear_blend_skinning_top] ERROR");
    $finish;
  end
endmodule
